>>> design/lpf_pkg.sv
`default_nettype none

package lpf_pkg;

   localparam int LPF_DETAIL_BITS = 32;

   localparam logic [15:0] BLINK_PERIOD_RESET = 16'd1000;
   localparam logic [14:0] SHORT_FLASH_RESET  = 15'd120;
   localparam logic        AUTO_PRESENT_RESET = 1'b1;

   localparam int CSR_ADDR_BITS = 4;

   typedef enum logic [1:0] {
      CSR_BLINK_PERIOD = 2'd0,
      CSR_SHORT_FLASH  = 2'd1,
      CSR_AUTO_PRESENT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      EV_TICK       = 4'd0,
      EV_STARTED    = 4'd1,
      EV_CONNECTED  = 4'd2,
      EV_IDENTIFY   = 4'd3,
      EV_RUN        = 4'd4,
      EV_AUTO_OFF   = 4'd5,
      EV_AUTO_ON    = 4'd6,
      EV_PRESS_OFF  = 4'd7,
      EV_PRESS_AUTO = 4'd8,
      EV_PRESS_ON   = 4'd9,
      EV_ERROR      = 4'd10
   } event_kind_type;

   typedef enum logic [1:0] {
      REQ_NONE = 2'd0,
      REQ_OFF  = 2'd1,
      REQ_ON   = 2'd2
   } power_req_type;

   typedef enum logic [1:0] {
      BLINK_NONE = 2'd0,
      BLINK_LOOP = 2'd1,
      BLINK_ALL  = 2'd2
   } blink_mode_type;

   typedef enum logic [3:0] {
      FL_IDLE      = 4'd0,
      FL_NUM_MARK  = 4'd1,
      FL_NUM_GAP   = 4'd2,
      FL_PAUSE     = 4'd3,
      FL_SIGN_MARK = 4'd4,
      FL_SIGN_GAP  = 4'd5,
      FL_DET_MARK  = 4'd6,
      FL_DET_GAP   = 4'd7
   } flash_phase_type;

   localparam logic [2:0] LAMP_OFF_BIT  = 3'b001;
   localparam logic [2:0] LAMP_AUTO_BIT = 3'b010;
   localparam logic [2:0] LAMP_ON_BIT   = 3'b100;

   typedef struct packed {
      logic [3:0]         kind;
      logic [7:0]         error_number;
      logic signed [31:0] error_detail;
   } req_item_type;

   typedef struct packed {
      logic       lamp_off;
      logic       lamp_auto;
      logic       lamp_on;
      logic [1:0] power_request;
      logic       running;
      logic       auto_active;
      logic       error_busy;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] blink_period_ticks;
      logic [14:0] short_flash_ticks;
      logic        auto_present;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic busy_next;
      logic enter;
      logic lit;
   } flash_ctl_type;

endpackage

`default_nettype wire

>>> design/lpf_csr.sv
`default_nettype none

module lpf_csr
   import lpf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type sel;

   assign sel    = csr_index_type'(paddr[3:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (sel)
            CSR_BLINK_PERIOD: cfg_in.blink_period_ticks = pwdata[15:0];
            CSR_SHORT_FLASH:  cfg_in.short_flash_ticks  = pwdata[14:0];
            CSR_AUTO_PRESENT: cfg_in.auto_present       = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         CSR_BLINK_PERIOD: prdata = {16'd0, cfg_ff.blink_period_ticks};
         CSR_SHORT_FLASH:  prdata = {17'd0, cfg_ff.short_flash_ticks};
         CSR_AUTO_PRESENT: prdata = {31'd0, cfg_ff.auto_present};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_period_ticks <= BLINK_PERIOD_RESET;
         cfg_ff.short_flash_ticks  <= SHORT_FLASH_RESET;
         cfg_ff.auto_present       <= AUTO_PRESENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> design/lpf_flash.sv
`default_nettype none

module lpf_flash
   import lpf_pkg::*;
#(
   parameter int DETAIL_BITS = LPF_DETAIL_BITS
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire req_item_type item,
   input  wire logic [14:0]  short_flash_ticks,
   output flash_ctl_type     ctl
);

   localparam int BPW = $clog2(DETAIL_BITS);

   flash_phase_type         phase_ff, phase_in;
   logic [BPW-1:0]          bitpos_ff, bitpos_in;
   logic [15:0]             count_ff, count_in;
   logic [7:0]              number_ff, number_in;
   logic [DETAIL_BITS-1:0]  mag_ff, mag_in;
   logic                    neg_ff, neg_in;

   logic [14:0]             short_len;
   logic [16:0]             triple;
   logic [15:0]             long_len;
   logic [15:0]             phase_len;
   logic [16:0]             count_inc;
   logic                    busy;
   logic                    step;
   logic                    start;
   logic                    done;
   logic [DETAIL_BITS-1:0]  detail_v;
   logic                    detail_neg;

   function automatic logic [BPW-1:0] top_bit(input logic [DETAIL_BITS-1:0] v);
      logic [BPW-1:0] idx;
      idx = '0;
      for (int i = 1; i < DETAIL_BITS; i++) begin
         if (v[i]) idx = BPW'(i);
      end
      return idx;
   endfunction

   assign busy       = (phase_ff != FL_IDLE);
   assign step       = fire && busy && (item.kind == EV_TICK);
   assign start      = fire && !busy && (item.kind == EV_ERROR);
   assign short_len  = (short_flash_ticks == 15'd0) ? 15'd1 : short_flash_ticks;
   assign triple     = {1'b0, short_len, 1'b0} + {2'b00, short_len};
   assign long_len   = triple[16] ? 16'hFFFF : triple[15:0];
   assign count_inc  = {1'b0, count_ff} + 17'd1;
   assign detail_v   = item.error_detail[DETAIL_BITS-1:0];
   assign detail_neg = detail_v[DETAIL_BITS-1];

   always_comb begin
      case (phase_ff)
         FL_NUM_MARK: phase_len = number_ff[bitpos_ff[2:0]] ? long_len : {1'b0, short_len};
         FL_PAUSE:    phase_len = long_len;
         FL_DET_MARK: phase_len = mag_ff[bitpos_ff] ? long_len : {1'b0, short_len};
         default:     phase_len = {1'b0, short_len};
      endcase
   end

   assign done = step && (count_inc >= {1'b0, phase_len});

   // next state
   always_comb begin
      phase_in  = phase_ff;
      bitpos_in = bitpos_ff;
      count_in  = count_ff;
      number_in = number_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      if (start) begin
         number_in = item.error_number;
         neg_in    = detail_neg;
         mag_in    = detail_neg ? DETAIL_BITS'(~detail_v + DETAIL_BITS'(1)) : detail_v;
         bitpos_in = top_bit(DETAIL_BITS'(item.error_number));
         count_in  = 16'd0;
         phase_in  = FL_NUM_MARK;
      end else if (step) begin
         if (!done) begin
            count_in = count_inc[15:0];
         end else begin
            count_in = 16'd0;
            case (phase_ff)
               FL_NUM_MARK: phase_in = FL_NUM_GAP;
               FL_NUM_GAP: begin
                  if (bitpos_ff != '0) begin
                     bitpos_in = bitpos_ff - BPW'(1);
                     phase_in  = FL_NUM_MARK;
                  end else begin
                     phase_in = FL_PAUSE;
                  end
               end
               FL_PAUSE: begin
                  if (neg_ff) begin
                     phase_in = FL_SIGN_MARK;
                  end else begin
                     bitpos_in = top_bit(mag_ff);
                     phase_in  = FL_DET_MARK;
                  end
               end
               FL_SIGN_MARK: phase_in = FL_SIGN_GAP;
               FL_SIGN_GAP: begin
                  bitpos_in = top_bit(mag_ff);
                  phase_in  = FL_DET_MARK;
               end
               FL_DET_MARK: phase_in = FL_DET_GAP;
               FL_DET_GAP: begin
                  if (bitpos_ff != '0) begin
                     bitpos_in = bitpos_ff - BPW'(1);
                     phase_in  = FL_DET_MARK;
                  end else begin
                     phase_in = FL_IDLE;
                  end
               end
               default: phase_in = FL_IDLE;
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      ctl.busy      = busy;
      ctl.busy_next = (phase_in != FL_IDLE);
      ctl.enter     = done;
      ctl.lit       = phase_in inside {FL_NUM_MARK, FL_SIGN_MARK, FL_DET_MARK};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= FL_IDLE;
         bitpos_ff <= '0;
         count_ff  <= 16'd0;
         number_ff <= 8'd0;
         mag_ff    <= '0;
         neg_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         bitpos_ff <= bitpos_in;
         count_ff  <= count_in;
         number_ff <= number_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
      end
   end

endmodule

`default_nettype wire

>>> design/lpf_panel.sv
`default_nettype none

module lpf_panel
   import lpf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire logic [3:0]    kind,
   input  wire cfg_type       cfg,
   input  wire flash_ctl_type flash,
   output rsp_item_type       result
);

   logic [2:0]     lamp_ff, lamp_in;
   blink_mode_type mode_ff, mode_in;
   logic [1:0]     loop_ff, loop_in;
   logic [15:0]    bcount_ff, bcount_in;
   logic           running_ff, running_in;
   logic           auto_ff, auto_in;
   power_req_type  request;

   logic [2:0]     all_lamps;
   logic [15:0]    period;
   logic [16:0]    bcount_inc;

   assign all_lamps  = LAMP_OFF_BIT | LAMP_ON_BIT | (cfg.auto_present ? LAMP_AUTO_BIT : 3'b000);
   assign period     = (cfg.blink_period_ticks == 16'd0) ? 16'd1 : cfg.blink_period_ticks;
   assign bcount_inc = {1'b0, bcount_ff} + 17'd1;

   always_comb begin
      logic [1:0] pos;
      logic [2:0] lamp_t;
      pos        = loop_ff;
      lamp_t     = lamp_ff;
      lamp_in    = lamp_ff;
      mode_in    = mode_ff;
      loop_in    = loop_ff;
      bcount_in  = bcount_ff;
      running_in = running_ff;
      auto_in    = auto_ff;
      request    = REQ_NONE;
      if (fire) begin
         if (flash.busy) begin
            if (kind == EV_TICK && flash.enter) lamp_in[2] = flash.lit;
         end else begin
            case (kind)
               EV_TICK: begin
                  if (mode_ff != BLINK_NONE) begin
                     if (bcount_inc >= {1'b0, period}) begin
                        bcount_in = 16'd0;
                        if (mode_ff == BLINK_ALL) begin
                           lamp_in = lamp_ff ^ all_lamps;
                        end else if (mode_ff == BLINK_LOOP) begin
                           if (pos == 2'd3) pos = 2'd0;
                           if (pos == 2'd1 && !cfg.auto_present) pos = 2'd2;
                           lamp_t = lamp_ff ^ (3'b001 << pos);
                           if (!lamp_t[pos]) begin
                              case (pos)
                                 2'd0:    pos = cfg.auto_present ? 2'd1 : 2'd2;
                                 2'd1:    pos = 2'd2;
                                 default: pos = 2'd0;
                              endcase
                           end
                           lamp_in = lamp_t;
                           loop_in = pos;
                        end
                     end else begin
                        bcount_in = bcount_inc[15:0];
                     end
                  end
               end
               EV_STARTED: begin
                  lamp_in   = 3'b000;
                  bcount_in = 16'd0;
                  mode_in   = BLINK_LOOP;
                  loop_in   = 2'd0;
               end
               EV_CONNECTED: begin
                  mode_in   = BLINK_NONE;
                  bcount_in = 16'd0;
                  lamp_in   = all_lamps;
               end
               EV_IDENTIFY: begin
                  lamp_in   = 3'b000;
                  bcount_in = 16'd0;
                  mode_in   = BLINK_ALL;
               end
               EV_RUN: begin
                  mode_in    = BLINK_NONE;
                  bcount_in  = 16'd0;
                  running_in = 1'b1;
                  if (cfg.auto_present) begin
                     auto_in = 1'b1;
                     lamp_in = LAMP_AUTO_BIT;
                  end else begin
                     lamp_in = LAMP_OFF_BIT;
                  end
               end
               EV_AUTO_OFF: if (auto_ff) request = REQ_OFF;
               EV_AUTO_ON:  if (auto_ff) request = REQ_ON;
               EV_PRESS_OFF: begin
                  if (running_ff) begin
                     lamp_in = LAMP_OFF_BIT;
                     auto_in = 1'b0;
                     request = REQ_OFF;
                  end
               end
               EV_PRESS_AUTO: begin
                  if (running_ff && cfg.auto_present) begin
                     lamp_in = LAMP_AUTO_BIT;
                     auto_in = 1'b1;
                  end
               end
               EV_PRESS_ON: begin
                  if (running_ff) begin
                     lamp_in = LAMP_ON_BIT;
                     auto_in = 1'b0;
                     request = REQ_ON;
                  end
               end
               EV_ERROR: begin
                  running_in = 1'b0;
                  auto_in    = 1'b0;
                  mode_in    = BLINK_NONE;
                  bcount_in  = 16'd0;
                  lamp_in    = LAMP_OFF_BIT | LAMP_ON_BIT;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      result.lamp_off      = lamp_in[0];
      result.lamp_auto     = lamp_in[1] & cfg.auto_present;
      result.lamp_on       = lamp_in[2];
      result.power_request = request;
      result.running       = running_in;
      result.auto_active   = auto_in;
      result.error_busy    = flash.busy_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_ff    <= 3'b000;
         mode_ff    <= BLINK_NONE;
         loop_ff    <= 2'd0;
         bcount_ff  <= 16'd0;
         running_ff <= 1'b0;
         auto_ff    <= 1'b0;
      end else begin
         lamp_ff    <= lamp_in;
         mode_ff    <= mode_in;
         loop_ff    <= loop_in;
         bcount_ff  <= bcount_in;
         running_ff <= running_in;
         auto_ff    <= auto_in;
      end
   end

endmodule

`default_nettype wire

>>> design/led_panel_mode_and_error_flasher_unit.sv
// Lamp panel controller for an off, an optional auto and an on button.
// Input channel req_: one event item per transfer (ticks are 1 ms, plus
// started, connected, identify, run, auto and press events and error reports).
// Result channel rsp_: exactly one item per event, carrying the lamp states,
// the power request and the running, auto and error-busy flags after it.
// Registers on the APB-style port: blink period at 0x0, short flash length at
// 0x4, auto-button presence at 0x8; the user must write them only while the
// block is idle, which the block itself does not enforce. An accepted item
// passes the input register, then the update logic into the result register.
// Throughput is one item per cycle while the pipeline is not held; panel and
// flasher state registers update once per item, so items stream back to back.
// When rsp_stall is high with a result waiting, the whole pipeline holds and
// req_stall rises in the same cycle; it drops once the result is taken.
// Reset clears all lamps, flags and the flash sequencer, empties the pipeline
// and loads the registers with 1000, 120 and 1.
`default_nettype none

module led_panel_mode_and_error_flasher_unit
   import lpf_pkg::*;
#(
   parameter int DETAIL_BITS = LPF_DETAIL_BITS
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_item_type             req_item,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_item_type                  rsp_item,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic          s1_valid_ff, s1_valid_in;
   req_item_type  s1_item_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff;
   logic          advance;
   logic          fire;
   cfg_type       cfg;
   flash_ctl_type flash;
   rsp_item_type  result;

   assign advance      = !(rsp_valid_ff && rsp_stall);
   assign req_stall    = !advance;
   assign fire         = s1_valid_ff && advance;
   assign s1_valid_in  = advance ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item     = rsp_item_ff;

   lpf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lpf_flash #(
      .DETAIL_BITS (DETAIL_BITS)
   ) u_flash (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .item              (s1_item_ff),
      .short_flash_ticks (cfg.short_flash_ticks),
      .ctl               (flash)
   );

   lpf_panel u_panel (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .kind   (s1_item_ff.kind),
      .cfg    (cfg),
      .flash  (flash),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) s1_item_ff <= req_item;
      if (fire) rsp_item_ff <= result;
   end

endmodule

`default_nettype wire
